// ===== design/mtb_pkg.sv =====
package mtb_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int TIMER_W    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int ID_W       = 4;

	localparam logic [15:0] INACTIVE = 16'hFFFF;

	localparam logic [2:0] REQ_TICK       = 3'd0;
	localparam logic [2:0] REQ_CREATE     = 3'd1;
	localparam logic [2:0] REQ_KILL       = 3'd2;
	localparam logic [2:0] REQ_SERVICE    = 3'd3;
	localparam logic [2:0] REQ_QUERY      = 3'd4;
	localparam logic [2:0] REQ_ELAPSED    = 3'd5;
	localparam logic [2:0] REQ_RESERVED_A = 3'd6;
	localparam logic [2:0] REQ_RESERVED_B = 3'd7;

	localparam logic [1:0] CFG_TASK_MAP  = 2'd0;
	localparam logic [1:0] CFG_POLL_DIV  = 2'd1;
	localparam logic [1:0] CFG_TICK_INCR = 2'd2;

	localparam logic [7:0] MODE_PERIODIC = 8'd0;
	localparam logic [7:0] MODE_ONE_SHOT = 8'd1;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [3:0]  timer_sel;
		logic [15:0] period;
		logic [7:0]  repeat_mode;
		logic [15:0] timer_param;
		logic [3:0]  task_id;
		logic [15:0] since_tick;
		logic [15:0] duration;
	} mtb_in_t;

	typedef struct packed {
		logic        fired;
		logic [3:0]  fired_timer;
		logic [15:0] fired_param;
		logic        timer_active;
		logic        time_passed;
		logic [15:0] system_tick;
		logic        last;
	} mtb_out_t;

	typedef struct packed {
		logic capture;
		logic execute;
		logic scan_step;
		logic emit;
	} mtb_cmd_t;

	typedef struct packed {
		logic scan_req;
		logic scan_done;
		logic out_free;
	} mtb_stat_t;

endpackage

// ===== design/mtb_ctrl.sv =====
module mtb_ctrl import mtb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  mtb_stat_t stat,
	output mtb_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = stat.scan_req ? ST_SCAN : ST_EMIT;
			end
			ST_SCAN: begin
				if (stat.scan_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign cmd.capture   = (state_q == ST_IDLE) && in_valid;
	assign cmd.execute   = (state_q == ST_EXEC);
	assign cmd.scan_step = (state_q == ST_SCAN);
	assign cmd.emit      = (state_q == ST_EMIT);

endmodule

// ===== design/mtb_datapath.sv =====
module mtb_datapath import mtb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mtb_in_t     in_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  mtb_cmd_t    cmd,
	output mtb_stat_t   stat,
	output logic        out_valid,
	input  logic        out_stall,
	output mtb_out_t    out_data
);

	logic [15:0] countdown_q    [NUM_TIMERS];
	logic [15:0] reload_q       [NUM_TIMERS];
	logic        has_reload_q   [NUM_TIMERS];
	logic [7:0]  mode_q         [NUM_TIMERS];
	logic [7:0]  runs_left_q    [NUM_TIMERS];
	logic [15:0] param_q        [NUM_TIMERS];

	logic [63:0]        task_map_q;
	logic [7:0]         poll_div_q;
	logic [7:0]         tick_incr_q;
	logic [7:0]         poll_count_q;
	logic [15:0]        tick_now_q;
	logic               step_q;
	mtb_in_t            req_q;
	logic [TIMER_W-1:0] scan_idx_q;
	logic               pend_valid_q;
	logic [3:0]         pend_id_q;
	logic [15:0]        pend_param_q;
	logic               out_valid_q;
	mtb_out_t           out_q;

	logic [TIMER_W-1:0] id_idx;
	logic               id_ok;
	logic [TIMER_W-1:0] rd_idx;
	logic [15:0]        cur_cd;
	logic [3:0]         owner;
	logic               is_tick;
	logic               is_serv;
	logic               fire;
	logic               hold;
	logic               fire_go;
	logic               out_free;
	logic               scan_last;
	logic [7:0]         poll_next;
	logic [15:0]        create_period;
	logic [7:0]         runs_next;
	logic [15:0]        fire_cd;
	logic [16:0]        span;
	logic               passed;
	logic               active;
	logic               final_load;

	assign id_idx  = req_q.timer_sel[TIMER_W-1:0];
	assign id_ok   = {1'b0, req_q.timer_sel} < (ID_W + 1)'(NUM_TIMERS);
	assign rd_idx  = cmd.scan_step ? scan_idx_q : id_idx;
	assign cur_cd  = countdown_q[rd_idx];
	assign owner   = task_map_q[{scan_idx_q, 2'b00} +: 4];
	assign is_tick = (req_q.req_type == REQ_TICK);
	assign is_serv = (req_q.req_type == REQ_SERVICE);

	assign out_free  = !out_valid_q || !out_stall;
	assign fire      = cmd.scan_step && is_serv && (owner == req_q.task_id) && (cur_cd == 16'd0);
	assign hold      = fire && pend_valid_q && !out_free;
	assign fire_go   = fire && !hold;
	assign scan_last = (scan_idx_q == TIMER_W'(NUM_TIMERS - 1));

	assign stat.scan_req  = is_tick || is_serv;
	assign stat.scan_done = scan_last && !hold;
	assign stat.out_free  = out_free;

	assign poll_next     = poll_count_q + 8'd1;
	assign create_period = (req_q.period == INACTIVE) ? (INACTIVE - 16'd1) : req_q.period;
	assign runs_next     = runs_left_q[scan_idx_q] - 8'd1;

	always_comb begin
		if (!has_reload_q[scan_idx_q]) begin
			fire_cd = INACTIVE;
		end else if (mode_q[scan_idx_q] == MODE_PERIODIC) begin
			fire_cd = reload_q[scan_idx_q];
		end else begin
			fire_cd = (runs_next != 8'd0) ? reload_q[scan_idx_q] : INACTIVE;
		end
	end

	always_comb begin
		if (req_q.since_tick > tick_now_q) begin
			span = (17'd65535 - {1'b0, req_q.since_tick}) + {1'b0, tick_now_q};
		end else begin
			span = {1'b0, tick_now_q} - {1'b0, req_q.since_tick};
		end
	end

	assign passed     = (req_q.req_type == REQ_ELAPSED) && (span > {1'b0, req_q.duration});
	assign active     = (req_q.req_type == REQ_QUERY) && id_ok && (cur_cd != INACTIVE);
	assign final_load = cmd.emit && out_free;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_map_q  <= 64'd0;
			poll_div_q  <= 8'd1;
			tick_incr_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TASK_MAP:  task_map_q  <= cfg_data;
				CFG_POLL_DIV:  poll_div_q  <= cfg_data[7:0];
				CFG_TICK_INCR: tick_incr_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_count_q <= 8'd0;
			tick_now_q   <= 16'd0;
			step_q       <= 1'b0;
			scan_idx_q   <= '0;
			pend_valid_q <= 1'b0;
			pend_id_q    <= 4'd0;
			pend_param_q <= 16'd0;
		end else if (cmd.execute) begin
			scan_idx_q   <= '0;
			pend_valid_q <= 1'b0;
			pend_id_q    <= 4'd0;
			pend_param_q <= 16'd0;
			if (is_tick) begin
				tick_now_q <= tick_now_q + {8'd0, tick_incr_q};
				if (poll_next >= poll_div_q) begin
					poll_count_q <= 8'd0;
					step_q       <= 1'b1;
				end else begin
					poll_count_q <= poll_next;
					step_q       <= 1'b0;
				end
			end
		end else if (cmd.scan_step && !hold) begin
			scan_idx_q <= scan_idx_q + TIMER_W'(1);
			if (fire_go) begin
				pend_valid_q <= 1'b1;
				pend_id_q    <= ID_W'(scan_idx_q);
				pend_param_q <= param_q[scan_idx_q];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				countdown_q[i]  <= INACTIVE;
				reload_q[i]     <= 16'd0;
				has_reload_q[i] <= 1'b0;
				mode_q[i]       <= 8'd0;
				runs_left_q[i]  <= 8'd0;
				param_q[i]      <= 16'd0;
			end
		end else if (cmd.execute && id_ok && (req_q.req_type == REQ_CREATE)) begin
			countdown_q[id_idx] <= create_period;
			mode_q[id_idx]      <= req_q.repeat_mode;
			runs_left_q[id_idx] <= req_q.repeat_mode;
			param_q[id_idx]     <= req_q.timer_param;
			if (req_q.repeat_mode == MODE_ONE_SHOT) begin
				has_reload_q[id_idx] <= 1'b0;
				reload_q[id_idx]     <= 16'd0;
			end else begin
				has_reload_q[id_idx] <= 1'b1;
				reload_q[id_idx]     <= create_period;
			end
		end else if (cmd.execute && id_ok && (req_q.req_type == REQ_KILL)) begin
			countdown_q[id_idx]  <= INACTIVE;
			has_reload_q[id_idx] <= 1'b0;
			param_q[id_idx]      <= 16'd0;
		end else if (cmd.scan_step && is_tick && step_q) begin
			if ((cur_cd != INACTIVE) && (cur_cd != 16'd0)) begin
				countdown_q[scan_idx_q] <= cur_cd - 16'd1;
			end
		end else if (fire_go) begin
			countdown_q[scan_idx_q] <= fire_cd;
			if (has_reload_q[scan_idx_q] && (mode_q[scan_idx_q] != MODE_PERIODIC)) begin
				runs_left_q[scan_idx_q] <= runs_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((fire_go && pend_valid_q) || final_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_go && pend_valid_q) begin
			out_q.fired        <= 1'b1;
			out_q.fired_timer  <= pend_id_q;
			out_q.fired_param  <= pend_param_q;
			out_q.timer_active <= 1'b0;
			out_q.time_passed  <= 1'b0;
			out_q.system_tick  <= tick_now_q;
			out_q.last         <= 1'b0;
		end else if (final_load) begin
			out_q.fired        <= pend_valid_q;
			out_q.fired_timer  <= pend_id_q;
			out_q.fired_param  <= pend_param_q;
			out_q.timer_active <= active;
			out_q.time_passed  <= passed;
			out_q.system_tick  <= tick_now_q;
			out_q.last         <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== design/multi_timer_bank_top.sv =====
// Tick and service words scan all timers one per cycle while the scan is not held: the final result
// word is loaded in the emit state once the output is free, and the next word is taken back in idle.
// Service holds the scan while an earlier fired result waits on a stalled output.
// Other requests go from execute straight to emit; no new word is taken until their result is loaded.
// Reset makes every timer inactive and clears the system tick and the poll count.
module multi_timer_bank_top import mtb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  mtb_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output mtb_out_t    out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	mtb_cmd_t  cmd;
	mtb_stat_t stat;

	mtb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	mtb_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a word is still in work");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.execute, cmd.scan_step, cmd.emit}))
		else $error("controller issued more than one command");

	a_final_word: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && stat.out_free) |=> (out_valid && out_data.last))
		else $error("final result word not presented with last set");
`endif

endmodule

// ===== bench/mtb_result_checker.sv =====
module mtb_result_checker import mtb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  mtb_in_t     in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  mtb_out_t    out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          words_due,
	output int          words_checked,
	output int          timers_fired
);

	logic [15:0] count_left [NUM_TIMERS];
	logic [15:0] reload_len [NUM_TIMERS];
	logic        reloads    [NUM_TIMERS];
	logic [7:0]  fire_mode  [NUM_TIMERS];
	logic [7:0]  fires_left [NUM_TIMERS];
	logic [15:0] user_param [NUM_TIMERS];
	logic [7:0]  poll_phase;
	logic [15:0] sys_tick;
	logic [63:0] owner_map;
	logic [7:0]  poll_div;
	logic [7:0]  tick_step;
	mtb_out_t    expected_words [$];
	mtb_out_t    want;

	task automatic report(input string field, input int got, input int wanted);
		if (fail_count < 25) begin
			$display("%0t: %s mismatch, got %0h, expected %0h", $time, field, got, wanted);
		end
		fail_count++;
	endtask

	function automatic void predict_request(input mtb_in_t w);
		mtb_out_t    words [$];
		mtb_out_t    r;
		logic [15:0] len;
		logic [16:0] span;
		int          i;
		r = '0;
		case (w.req_type)
			REQ_TICK: begin
				sys_tick = sys_tick + {8'd0, tick_step};
				poll_phase = poll_phase + 8'd1;
				if (poll_phase >= poll_div) begin
					poll_phase = 8'd0;
					for (i = 0; i < NUM_TIMERS; i++) begin
						if (count_left[i] != INACTIVE && count_left[i] != 16'd0) begin
							count_left[i] = count_left[i] - 16'd1;
						end
					end
				end
			end
			REQ_CREATE: begin
				if (int'(w.timer_sel) < NUM_TIMERS) begin
					len = (w.period == INACTIVE) ? INACTIVE - 16'd1 : w.period;
					count_left[w.timer_sel] = len;
					fire_mode[w.timer_sel] = w.repeat_mode;
					fires_left[w.timer_sel] = w.repeat_mode;
					reloads[w.timer_sel] = (w.repeat_mode != MODE_ONE_SHOT);
					reload_len[w.timer_sel] = (w.repeat_mode != MODE_ONE_SHOT) ? len : 16'd0;
					user_param[w.timer_sel] = w.timer_param;
				end
			end
			REQ_KILL: begin
				if (int'(w.timer_sel) < NUM_TIMERS) begin
					count_left[w.timer_sel] = INACTIVE;
					reloads[w.timer_sel] = 1'b0;
					user_param[w.timer_sel] = 16'd0;
				end
			end
			REQ_SERVICE: begin
				for (i = 0; i < NUM_TIMERS; i++) begin
					if (owner_map[4 * i +: 4] == w.task_id && count_left[i] == 16'd0) begin
						// A repeat count of zero means the timer reloads forever.
						if (!reloads[i]) begin
							count_left[i] = INACTIVE;
						end else if (fire_mode[i] == MODE_PERIODIC) begin
							count_left[i] = reload_len[i];
						end else begin
							fires_left[i] = fires_left[i] - 8'd1;
							count_left[i] = (fires_left[i] != 8'd0) ? reload_len[i] : INACTIVE;
						end
						r = '0;
						r.fired = 1'b1;
						r.fired_timer = i[3:0];
						r.fired_param = user_param[i];
						r.system_tick = sys_tick;
						words.push_back(r);
					end
				end
				r = '0;
			end
			REQ_QUERY: begin
				r.timer_active = (int'(w.timer_sel) < NUM_TIMERS)
					&& (count_left[w.timer_sel] != INACTIVE);
			end
			REQ_ELAPSED: begin
				if (w.since_tick > sys_tick) begin
					span = (17'd65535 - {1'b0, w.since_tick}) + {1'b0, sys_tick};
				end else begin
					span = {1'b0, sys_tick} - {1'b0, w.since_tick};
				end
				r.time_passed = (span > {1'b0, w.duration});
			end
			default: ;
		endcase
		if (words.size() == 0) begin
			r.system_tick = sys_tick;
			words.push_back(r);
		end
		r = words.pop_back();
		r.last = 1'b1;
		words.push_back(r);
		foreach (words[k]) begin
			expected_words.push_back(words[k]);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				count_left[i] = INACTIVE;
				reload_len[i] = 16'd0;
				reloads[i] = 1'b0;
				fire_mode[i] = 8'd0;
				fires_left[i] = 8'd0;
				user_param[i] = 16'd0;
			end
			poll_phase = 8'd0;
			sys_tick = 16'd0;
			owner_map = 64'd0;
			poll_div = 8'd1;
			tick_step = 8'd1;
			expected_words.delete();
			words_due = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TASK_MAP:  owner_map = cfg_data;
					CFG_POLL_DIV:  poll_div = cfg_data[7:0];
					CFG_TICK_INCR: tick_step = cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report("unexpected word, system_tick", int'(out_data.system_tick), 0);
				end else begin
					want = expected_words.pop_front();
					if (out_data.fired !== want.fired)
						report("fired", int'(out_data.fired), int'(want.fired));
					if (out_data.fired_timer !== want.fired_timer)
						report("fired_timer", int'(out_data.fired_timer),
							int'(want.fired_timer));
					if (out_data.fired_param !== want.fired_param)
						report("fired_param", int'(out_data.fired_param),
							int'(want.fired_param));
					if (out_data.timer_active !== want.timer_active)
						report("timer_active", int'(out_data.timer_active),
							int'(want.timer_active));
					if (out_data.time_passed !== want.time_passed)
						report("time_passed", int'(out_data.time_passed),
							int'(want.time_passed));
					if (out_data.system_tick !== want.system_tick)
						report("system_tick", int'(out_data.system_tick),
							int'(want.system_tick));
					if (out_data.last !== want.last)
						report("last", int'(out_data.last), int'(want.last));
					words_checked++;
					if (want.fired) begin
						timers_fired++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				predict_request(in_data);
			end
			words_due = expected_words.size();
		end
	end

endmodule

// ===== bench/tb_multi_timer_bank_top.sv =====
module tb_multi_timer_bank_top;
	import mtb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	mtb_in_t     in_data;
	logic        out_valid;
	logic        out_stall;
	mtb_out_t    out_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	int          fail_count;
	int          words_due;
	int          words_checked;
	int          timers_fired;
	logic        hold_toggle;
	logic [63:0] cur_task_map;
	int          words_sent;
	int          settings_used;

	multi_timer_bank_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mtb_result_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.words_due     (words_due),
		.words_checked (words_checked),
		.timers_fired  (timers_fired)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5000000;
		$display("[multi_timer_bank_top] ERROR");
		$finish;
	end

	// The receiver picks a new random stall pattern whenever the current one runs out. A toggle of
	// hold_toggle makes it hold off completely before the patterns resume.
	initial begin : receiver
		int          hold;
		int          pattern_left;
		logic [31:0] pattern;
		logic        seen;
		out_stall = 1'b0;
		hold = 0;
		pattern_left = 0;
		pattern = '0;
		seen = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_toggle != seen) begin
				seen = hold_toggle;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				if (pattern_left == 0) begin
					pattern_left = $urandom_range(20, 120);
					case ($urandom_range(0, 3))
						0: pattern = '0;
						1: pattern = $urandom;
						2: pattern = $urandom | $urandom;
						default: pattern = $urandom & $urandom;
					endcase
				end
				pattern_left--;
				out_stall <= pattern[0];
				pattern = {pattern[0], pattern[31:1]};
			end
		end
	end

	function automatic mtb_in_t make_word(input logic [2:0] req, input logic [3:0] id,
		input logic [15:0] per, input logic [7:0] mode, input logic [15:0] prm,
		input logic [3:0] tsk, input logic [15:0] since, input logic [15:0] dur);
		mtb_in_t w;
		w.req_type = req;
		w.timer_sel = id;
		w.period = per;
		w.repeat_mode = mode;
		w.timer_param = prm;
		w.task_id = tsk;
		w.since_tick = since;
		w.duration = dur;
		return w;
	endfunction

	// Mostly short timers and services aimed at tasks that own timers, so that
	// expirations are frequent; the rest of each word is random.
	function automatic mtb_in_t pick_request();
		mtb_in_t w;
		int      roll;
		int      k;
		w.req_type = 3'($urandom_range(0, 7));
		w.timer_sel = 4'($urandom_range(0, 15));
		w.period = 16'($urandom_range(0, 65535));
		w.repeat_mode = 8'($urandom_range(0, 255));
		w.timer_param = 16'($urandom_range(0, 65535));
		w.task_id = 4'($urandom_range(0, 15));
		w.since_tick = 16'($urandom_range(0, 65535));
		w.duration = 16'($urandom_range(0, 65535));
		roll = $urandom_range(0, 99);
		if (roll < 32) begin
			w.req_type = REQ_TICK;
		end else if (roll < 52) begin
			w.req_type = REQ_CREATE;
			case ($urandom_range(0, 9))
				0: ;
				1: w.period = INACTIVE;
				default: w.period = 16'($urandom_range(0, 6));
			endcase
			if ($urandom_range(0, 3) != 0) begin
				w.repeat_mode = 8'($urandom_range(0, 4));
			end
		end else if (roll < 72) begin
			w.req_type = REQ_SERVICE;
			k = $urandom_range(0, 15);
			if ($urandom_range(0, 6) != 0) begin
				w.task_id = cur_task_map[4 * k +: 4];
			end
		end else if (roll < 80) begin
			w.req_type = REQ_KILL;
		end else if (roll < 88) begin
			w.req_type = REQ_QUERY;
		end else if (roll < 96) begin
			w.req_type = REQ_ELAPSED;
		end else begin
			w.req_type = ($urandom_range(0, 1) == 0) ? REQ_RESERVED_A : REQ_RESERVED_B;
		end
		return w;
	endfunction

	task automatic send_word(input mtb_in_t w);
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		words_sent++;
	endtask

	task automatic run_items(input int count, input bit gappy);
		int burst;
		burst = $urandom_range(1, 12);
		repeat (count) begin
			send_word(pick_request());
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				if (gappy) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
			end
		end
	endtask

	task automatic wait_quiet();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic write_settings(input logic [63:0] map, input logic [7:0] div,
		input logic [7:0] incr);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TASK_MAP;
		cfg_data <= map;
		@(posedge clk);
		cfg_index <= CFG_POLL_DIV;
		cfg_data <= {56'd0, div};
		@(posedge clk);
		cfg_index <= CFG_TICK_INCR;
		cfg_data <= {56'd0, incr};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_task_map = map;
		settings_used++;
	endtask

	initial begin : stimulus
		int          p;
		logic [63:0] map;
		logic [7:0]  div;
		logic [7:0]  incr;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_TASK_MAP;
		cfg_data = '0;
		hold_toggle = 1'b0;
		cur_task_map = '0;
		words_sent = 0;
		settings_used = 1;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset every timer belongs to task zero.
		send_word(make_word(REQ_CREATE, 4'd0, 16'd0, MODE_PERIODIC, 16'hFFFF, 4'd0, 16'd0,
			16'd0));
		send_word(make_word(REQ_CREATE, 4'd15, INACTIVE, MODE_ONE_SHOT, 16'h1234, 4'd0,
			16'd0, 16'd0));
		send_word(make_word(REQ_CREATE, 4'd1, 16'd2, MODE_ONE_SHOT, 16'h0001, 4'd0,
			16'd0, 16'd0));
		send_word(make_word(REQ_CREATE, 4'd2, 16'd1, 8'd3, 16'hBEEF, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_CREATE, 4'd3, 16'd1, 8'd255, 16'h8001, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_QUERY, 4'd15, 16'd0, 8'd0, 16'd0, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_QUERY, 4'd4, 16'd0, 8'd0, 16'd0, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_TICK, 4'd0, 16'd0, 8'd0, 16'd0, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_TICK, 4'd0, 16'd0, 8'd0, 16'd0, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_SERVICE, 4'd0, 16'd0, 8'd0, 16'd0, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_SERVICE, 4'd0, 16'd0, 8'd0, 16'd0, 4'd15, 16'd0, 16'd0));
		send_word(make_word(REQ_KILL, 4'd15, 16'd0, 8'd0, 16'd0, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_QUERY, 4'd15, 16'd0, 8'd0, 16'd0, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_ELAPSED, 4'd0, 16'd0, 8'd0, 16'd0, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_ELAPSED, 4'd0, 16'd0, 8'd0, 16'd0, 4'd0, 16'hFFFF, 16'd1));
		send_word(make_word(REQ_ELAPSED, 4'd0, 16'd0, 8'd0, 16'd0, 4'd0, 16'd3, 16'hFFFF));
		send_word(make_word(REQ_ELAPSED, 4'd0, 16'd0, 8'd0, 16'd0, 4'd0, 16'd2, 16'd0));
		send_word(make_word(REQ_RESERVED_A, 4'd9, 16'h5A5A, 8'hA5, 16'h1111, 4'd3, 16'd7,
			16'd9));
		send_word(make_word(REQ_RESERVED_B, 4'd6, 16'hA5A5, 8'h5A, 16'h2222, 4'd12, 16'd1,
			16'd2));
		send_word(make_word(REQ_TICK, 4'd0, 16'd0, 8'd0, 16'd0, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_SERVICE, 4'd0, 16'd0, 8'd0, 16'd0, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_CREATE, 4'd4, 16'd0, 8'd2, 16'h8000, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_SERVICE, 4'd0, 16'd0, 8'd0, 16'd0, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_KILL, 4'd0, 16'd0, 8'd0, 16'd0, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_TICK, 4'd0, 16'd0, 8'd0, 16'd0, 4'd0, 16'd0, 16'd0));
		send_word(make_word(REQ_SERVICE, 4'd0, 16'd0, 8'd0, 16'd0, 4'd0, 16'd0, 16'd0));
		wait_quiet();

		for (p = 0; p < 7; p++) begin
			case (p)
				0: begin
					map = {$urandom, $urandom};
					div = 8'd1;
					incr = 8'd1;
				end
				1: begin
					map = '1;
					div = 8'd255;
					incr = 8'd255;
				end
				2: begin
					map = '0;
					div = 8'd0;
					incr = 8'($urandom_range(1, 255));
				end
				default: begin
					map = {$urandom, $urandom};
					div = 8'($urandom_range(1, 3));
					incr = 8'($urandom_range(1, 255));
				end
			endcase
			write_settings(map, div, incr);
			if (p == 1) begin
				// The output holds off while the input keeps offering words.
				hold_toggle = ~hold_toggle;
				repeat (30) send_word(pick_request());
			end
			run_items((p == 1) ? 20 : 22, p != 4);
			if (p == 3) begin
				wait_quiet();
			end
			run_items(22, p != 4);
			wait_quiet();
		end

		if (words_due != 0) begin
			$display("%0d expected result words never arrived", words_due);
		end
		$display("Sent %0d requests under %0d register settings.", words_sent, settings_used);
		$display("Checked %0d result words, %0d of them serviced timer expirations.",
			words_checked, timers_fired);
		if (fail_count == 0 && words_due == 0) begin
			$display("[multi_timer_bank_top] OK");
		end else begin
			$display("[multi_timer_bank_top] ERROR");
		end
		$finish;
	end

endmodule
